// File: rtl/core/rvtrap_pkg.sv
// Package: payload types, codes and helper functions of the trap entry unit.
`default_nettype none
package rvtrap_pkg;

  localparam int WORD_BITS = 32;
  localparam int INTR_BITS = 12;
  localparam int STATUS_BITS = 13;
  localparam int CFG_INDEX_BITS = 3;
  localparam int PRIO_COUNT = 6;

  localparam int ST_SIE = 1;
  localparam int ST_MIE = 3;
  localparam int ST_SPIE = 5;
  localparam int ST_MPIE = 7;
  localparam int ST_SPP = 8;
  localparam int ST_MPP_LO = 11;
  localparam int ST_MPP_HI = 12;

  localparam logic [1:0] PRIV_U = 2'd0;
  localparam logic [1:0] PRIV_S = 2'd1;
  localparam logic [1:0] PRIV_M = 2'd3;

  localparam logic [1:0] TVEC_VECTORED = 2'd1;

  typedef enum logic [1:0] {
    ACT_RAISE = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_LOAD  = 2'd2,
    ACT_NONE  = 2'd3
  } rvtrap_action_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_MTVEC   = 3'd0,
    CFG_STVEC   = 3'd1,
    CFG_MEDELEG = 3'd2,
    CFG_MIDELEG = 3'd3,
    CFG_MIE     = 3'd4
  } rvtrap_cfg_index_t;

  localparam logic [4:0] EXC_INST_MISALIGNED = 5'd0;
  localparam logic [4:0] EXC_INST_ACCESS     = 5'd1;
  localparam logic [4:0] EXC_ILLEGAL_INST    = 5'd2;
  localparam logic [4:0] EXC_BREAKPOINT      = 5'd3;
  localparam logic [4:0] EXC_LOAD_MISALIGNED = 5'd4;
  localparam logic [4:0] EXC_LOAD_ACCESS     = 5'd5;
  localparam logic [4:0] EXC_STORE_MISALIGNED = 5'd6;
  localparam logic [4:0] EXC_STORE_ACCESS    = 5'd7;
  localparam logic [4:0] EXC_INST_PAGE       = 5'd12;
  localparam logic [4:0] EXC_LOAD_PAGE       = 5'd13;
  localparam logic [4:0] EXC_STORE_PAGE      = 5'd15;

  localparam logic [3:0] PRIO_ORDER [PRIO_COUNT] = '{
    4'd11, 4'd3, 4'd7, 4'd9, 4'd1, 4'd5
  };

  typedef struct packed {
    logic [1:0]             action;
    logic                   is_interrupt;
    logic [4:0]             cause_code;
    logic [WORD_BITS-1:0]   epc;
    logic [WORD_BITS-1:0]   fault_address;
    logic [WORD_BITS-1:0]   instruction;
    logic [INTR_BITS-1:0]   pending_interrupts;
    logic [1:0]             new_privilege;
    logic [STATUS_BITS-1:0] new_status;
  } rvtrap_in_t;

  typedef struct packed {
    logic [WORD_BITS-1:0]   handler_pc;
    logic                   to_supervisor;
    logic                   tlb_flush;
    logic                   interrupt_found;
    logic [3:0]             interrupt_code;
    logic [1:0]             privilege_now;
    logic [STATUS_BITS-1:0] status_now;
    logic [WORD_BITS-1:0]   trap_cause;
    logic [WORD_BITS-1:0]   trap_epc;
    logic [WORD_BITS-1:0]   trap_value;
  } rvtrap_out_t;

  function automatic logic [WORD_BITS-1:0] pick_tval(
    input logic [4:0]           code,
    input logic [WORD_BITS-1:0] epc,
    input logic [WORD_BITS-1:0] addr,
    input logic [WORD_BITS-1:0] inst
  );
    logic [WORD_BITS-1:0] tval;
    case (code) inside
      EXC_ILLEGAL_INST: tval = inst;
      EXC_INST_MISALIGNED, EXC_INST_ACCESS: tval = (addr != '0) ? addr : epc;
      EXC_BREAKPOINT, EXC_INST_PAGE: tval = epc;
      EXC_LOAD_MISALIGNED, EXC_LOAD_ACCESS, EXC_STORE_MISALIGNED, EXC_STORE_ACCESS,
      EXC_LOAD_PAGE, EXC_STORE_PAGE: tval = addr;
      default: tval = '0;
    endcase
    return tval;
  endfunction

  function automatic logic [WORD_BITS-1:0] vector_target(
    input logic [WORD_BITS-1:0] tvec,
    input logic                 intr,
    input logic [4:0]           code
  );
    logic [WORD_BITS-1:0] base;
    base = {tvec[WORD_BITS-1:2], 2'b00};
    if (tvec[1:0] == TVEC_VECTORED && intr) begin
      return base + WORD_BITS'({code, 2'b00});
    end
    return base;
  endfunction

  function automatic logic takeable(
    input logic             delegated,
    input logic [1:0]       priv,
    input logic [STATUS_BITS-1:0] status
  );
    if (delegated) begin
      return (priv == PRIV_U) || (priv == PRIV_S && status[ST_SIE]);
    end
    return (priv != PRIV_M) || status[ST_MIE];
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/riscv_trap_entry_and_interrupt_select_unit.sv
// Top level: trap entry, delegation and interrupt selection unit.
// An input beat passes the input register, then the result register, to become a result beat.
// Throughput: one beat per cycle while out_ready does not stall; trap logic sits between the two registers.
// Privilege and status update as an item moves into the result register.
// Reset: synchronous; privilege to machine mode, status, config registers and valid flags to zero.
// No clearing pass; ready as soon as reset is released.
`default_nettype none
module riscv_trap_entry_and_interrupt_select_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire rvtrap_pkg::rvtrap_in_t              in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output rvtrap_pkg::rvtrap_out_t                  out_data,
  input  wire logic                                cfg_write,
  input  wire logic [rvtrap_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [rvtrap_pkg::WORD_BITS-1:0]    cfg_data
);
  import rvtrap_pkg::*;

  logic [WORD_BITS-1:0]   mtvec;
  logic [WORD_BITS-1:0]   stvec;
  logic [WORD_BITS-1:0]   medeleg;
  logic [INTR_BITS-1:0]   mideleg;
  logic [INTR_BITS-1:0]   mie;

  logic [1:0]             privilege;
  logic [1:0]             privilege_next;
  logic [STATUS_BITS-1:0] status;
  logic [STATUS_BITS-1:0] status_next;

  logic                   s1_valid;
  rvtrap_in_t             s1_data;
  rvtrap_out_t            result_next;

  logic                   out_free;
  logic                   advance;

  assign out_free = !out_valid || out_ready;
  assign advance  = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      mtvec   <= '0;
      stvec   <= '0;
      medeleg <= '0;
      mideleg <= '0;
      mie     <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MTVEC:   mtvec   <= cfg_data;
        CFG_STVEC:   stvec   <= cfg_data;
        CFG_MEDELEG: medeleg <= cfg_data;
        CFG_MIDELEG: mideleg <= cfg_data[INTR_BITS-1:0];
        CFG_MIE:     mie     <= cfg_data[INTR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_data <= in_data;
    end
  end

  always_comb begin
    logic [15:0]          mideleg_ext;
    logic                 deleg;
    logic                 intr;
    logic [4:0]           code;
    logic [WORD_BITS-1:0] tval;
    logic [INTR_BITS-1:0] live;
    logic                 found;

    mideleg_ext    = {{(16-INTR_BITS){1'b0}}, mideleg};
    intr           = s1_data.is_interrupt;
    code           = s1_data.cause_code;
    privilege_next = privilege;
    status_next    = status;
    result_next    = '0;
    deleg          = 1'b0;
    tval           = '0;
    live           = s1_data.pending_interrupts & mie;
    found          = 1'b0;

    case (s1_data.action)
      ACT_RAISE: begin
        tval = intr ? '0 : pick_tval(code, s1_data.epc, s1_data.fault_address,
                                     s1_data.instruction);
        if (privilege == PRIV_U || privilege == PRIV_S) begin
          deleg = intr ? (!code[4] && mideleg_ext[code[3:0]]) : medeleg[code];
        end
        if (deleg) begin
          status_next[ST_SPP]  = privilege[0];
          status_next[ST_SPIE] = status[ST_SIE];
          status_next[ST_SIE]  = 1'b0;
          privilege_next       = PRIV_S;
          result_next.handler_pc = vector_target(stvec, intr, code);
        end else begin
          status_next[ST_MPP_HI:ST_MPP_LO] = privilege;
          status_next[ST_MPIE] = status[ST_MIE];
          status_next[ST_MIE]  = 1'b0;
          privilege_next       = PRIV_M;
          result_next.handler_pc = vector_target(mtvec, intr, code);
        end
        result_next.to_supervisor = deleg;
        result_next.tlb_flush     = 1'b1;
        result_next.trap_cause    = {intr, {(WORD_BITS-6){1'b0}}, code};
        result_next.trap_epc      = s1_data.epc;
        result_next.trap_value    = tval;
      end
      ACT_QUERY: begin
        for (int i = PRIO_COUNT - 1; i >= 0; i--) begin
          if (live[PRIO_ORDER[i]] &&
              takeable(mideleg[PRIO_ORDER[i]], privilege, status)) begin
            found = 1'b1;
            result_next.interrupt_code = PRIO_ORDER[i];
          end
        end
        result_next.interrupt_found = found;
      end
      ACT_LOAD: begin
        privilege_next = s1_data.new_privilege;
        status_next    = s1_data.new_status;
      end
      default: ;
    endcase

    result_next.privilege_now = privilege_next;
    result_next.status_now    = status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      privilege <= PRIV_M;
      status    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= s1_valid;
      end
      if (advance) begin
        privilege <= privilege_next;
        status    <= status_next;
      end
    end
    if (advance) begin
      out_data <= result_next;
    end
  end

  a_sup_entry: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.to_supervisor |->
      out_data.tlb_flush && out_data.privilege_now == PRIV_S &&
      !out_data.status_now[ST_SIE])
    else $error("supervisor entry beat without S privilege or with SIE set");

  a_mach_entry: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.tlb_flush && !out_data.to_supervisor |->
      out_data.privilege_now == PRIV_M && !out_data.status_now[ST_MIE])
    else $error("machine entry beat without M privilege or with MIE set");

  a_query_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.interrupt_found |->
      !out_data.tlb_flush && out_data.handler_pc == '0)
    else $error("query beat carries trap results");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_data))
    else $error("input stage lost a beat while the result register was full");

  a_query_keeps_state: assert property (@(posedge clk) disable iff (rst)
    advance && s1_data.action == ACT_QUERY |=>
      privilege == $past(privilege) && status == $past(status))
    else $error("query changed privilege or status");

endmodule
`default_nettype wire
